[rtl/tbc_pkg.sv]
// Shared types and constants for the byte-wide Trivium cipher.
// No dependencies; imported by every module in rtl/.
package tbc_pkg;

    // Register lengths of the 288-bit state
    localparam int LEN_A = 93;
    localparam int LEN_B = 84;
    localparam int LEN_C = 111;

    // Key and IV width, split into a 64-bit low word and a 16-bit high word
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 16;
    localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;

    localparam int DATA_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Parameter defaults
    localparam int INIT_ROUNDS_DEF   = 1152;
    localparam int BITS_PER_ITEM_DEF = 8;

    // Operation codes
    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_CRYPT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

    // What one round lane produces: keystream bit and the three feedback bits
    typedef struct packed {
        logic z;
        logic fa;
        logic fb;
        logic fc;
    } lane_out_t;

endpackage

[rtl/trivium_byte_cipher.sv]
// Trivium byte cipher, top level. Encrypt request: BITS_PER_ITEM rounds at once
// from parallel lanes, result registered in the cycle after accept, 1 byte/cycle
// unless stalled. Init request: load key and IV, then INIT_ROUNDS warm-up rounds,
// BITS_PER_ITEM per step, the remainder one per step; input stalls meanwhile.
// Reset (rst_n, async low) clears key, IV, state and output valid.
// Depends on tbc_pkg, tbc_lane, tbc_merge.
module trivium_byte_cipher import tbc_pkg::*;
#(
    parameter int INIT_ROUNDS   = INIT_ROUNDS_DEF,
    parameter int BITS_PER_ITEM = BITS_PER_ITEM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [DATA_W-1:0]     data_byte,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_W-1:0]     result_byte,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WIDE_STEPS  = INIT_ROUNDS / BITS_PER_ITEM;
    localparam int INIT_STEPS  = WIDE_STEPS + INIT_ROUNDS % BITS_PER_ITEM;
    localparam int CNT_W       = (INIT_STEPS < 2) ? 1 : $clog2(INIT_STEPS);
    localparam int KS_W        = (BITS_PER_ITEM < DATA_W) ? DATA_W : BITS_PER_ITEM;

    typedef enum logic [1:0] {
        ST_READY  = 2'b01,
        ST_WARMUP = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [KEY_LOW_W-1:0]    key_low_reg, iv_low_reg;
    logic [KEY_HIGH_W-1:0]   key_high_reg, iv_high_reg;

    logic [LEN_A-1:0]        a_reg, a_next, a_step;
    logic [LEN_B-1:0]        b_reg, b_next, b_step;
    logic [LEN_C-1:0]        c_reg, c_next, c_step;

    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       result_reg, result_next;

    lane_out_t [BITS_PER_ITEM-1:0] lanes;
    logic [BITS_PER_ITEM-1:0]      keystream;
    logic [KS_W-1:0]               ks_ext;

    logic in_take;
    logic out_take;
    logic take_init;
    logic take_crypt;
    logic single_step;
    logic warm_last;

    // Handshakes
    assign out_take   = out_valid_reg && !out_stall;
    assign in_stall   = (state_reg != ST_READY) || (out_valid_reg && out_stall);
    assign in_take    = in_valid && !in_stall;
    assign take_init  = in_take && (operation == OP_INIT);
    assign take_crypt = in_take && (operation == OP_CRYPT);
    assign cfg_ready  = 1'b1;

    // Round lanes, all reading the current state
    for (genvar k = 0; k < BITS_PER_ITEM; k++)
    begin : g_lane
        tbc_lane #(.LANE(k)) u_lane (
            .a_state (a_reg),
            .b_state (b_reg),
            .c_state (c_reg),
            .lane    (lanes[k])
        );
    end

    // Tail of warm-up runs one round a cycle
    assign single_step = (state_reg == ST_WARMUP) && (32'(cnt_reg) >= WIDE_STEPS);
    assign warm_last   = (32'(cnt_reg) == INIT_STEPS - 1);

    tbc_merge #(.LANES(BITS_PER_ITEM)) u_merge (
        .a_state     (a_reg),
        .b_state     (b_reg),
        .c_state     (c_reg),
        .lanes       (lanes),
        .single_step (single_step),
        .a_step      (a_step),
        .b_step      (b_step),
        .c_step      (c_step),
        .keystream   (keystream)
    );

    // Control: ready / warm-up sequencing
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_READY:
            begin
                if (take_init && (INIT_STEPS > 0))
                begin
                    state_next = ST_WARMUP;
                    cnt_next   = '0;
                end
            end
            ST_WARMUP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (warm_last)
                begin
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    // Cipher state: load on init, step during warm-up or on encrypt
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        priority if (take_init)
        begin
            a_next = {{(LEN_A-KEY_W){1'b0}}, key_high_reg, key_low_reg};
            b_next = {{(LEN_B-KEY_W){1'b0}}, iv_high_reg, iv_low_reg};
            c_next = {3'b111, {(LEN_C-3){1'b0}}};
        end
        else if ((state_reg == ST_WARMUP) || take_crypt)
        begin
            a_next = a_step;
            b_next = b_step;
            c_next = c_step;
        end
        else
        begin
            a_next = a_reg;
        end
    end

    // Output register
    assign ks_ext = KS_W'(keystream);
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_take;
        result_next    = result_reg;
        if (take_crypt)
        begin
            out_valid_next = 1'b1;
            result_next    = data_byte ^ ks_ext[DATA_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            iv_low_reg    <= '0;
            iv_high_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
                    CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                    CFG_IV_HIGH:  iv_high_reg  <= cfg_data[KEY_HIGH_W-1:0];
                    default:      key_low_reg  <= key_low_reg;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

    // Checks
    a_warm_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WARMUP) |-> in_stall)
        else $error("request accepted during warm-up");

    a_warm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WARMUP) |-> (32'(cnt_reg) < INIT_STEPS))
        else $error("warm-up counter overran");

    a_crypt_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_crypt |=> out_valid)
        else $error("encrypt request gave no result");

    a_init_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take_init |=> (out_valid == $past(out_valid && out_stall)))
        else $error("init request produced a result");

endmodule

[rtl/tbc_lane.sv]
// One Trivium round lane: round LANE of a block, read from the state at its start.
// Depends on tbc_pkg (register lengths, lane_out_t).
module tbc_lane import tbc_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic [LEN_A-1:0] a_state,
    input  logic [LEN_B-1:0] b_state,
    input  logic [LEN_C-1:0] c_state,
    output lane_out_t        lane
);

    logic t1;
    logic t2;
    logic t3;

    // Taps shifted by LANE: bit p after LANE rounds sits at p-LANE now.
    // All taps are at 65 or above, so up to 64 lanes stay independent.
    assign t1 = a_state[65-LANE] ^ a_state[92-LANE];
    assign t2 = b_state[68-LANE] ^ b_state[83-LANE];
    assign t3 = c_state[65-LANE] ^ c_state[110-LANE];

    assign lane.z  = t1 ^ t2 ^ t3;
    assign lane.fb = t1 ^ (a_state[90-LANE] & a_state[91-LANE]) ^ b_state[77-LANE];
    assign lane.fc = t2 ^ (b_state[81-LANE] & b_state[82-LANE]) ^ c_state[86-LANE];
    assign lane.fa = t3 ^ (c_state[108-LANE] & c_state[109-LANE]) ^ a_state[68-LANE];

endmodule

[rtl/tbc_merge.sv]
// Merge stage: folds the lane feedback bits into the shifted state and packs
// the keystream word. Depends on tbc_pkg.
module tbc_merge import tbc_pkg::*;
#(
    parameter int LANES = BITS_PER_ITEM_DEF
)
(
    input  logic [LEN_A-1:0]      a_state,
    input  logic [LEN_B-1:0]      b_state,
    input  logic [LEN_C-1:0]      c_state,
    input  lane_out_t [LANES-1:0] lanes,
    input  logic                  single_step,
    output logic [LEN_A-1:0]      a_step,
    output logic [LEN_B-1:0]      b_step,
    output logic [LEN_C-1:0]      c_step,
    output logic [LANES-1:0]      keystream
);

    logic [LEN_A-1:0] a_wide;
    logic [LEN_B-1:0] b_wide;
    logic [LEN_C-1:0] c_wide;

    // Full block: shift by LANES, newest round lands in bit 0
    always_comb
    begin
        a_wide = {a_state[LEN_A-1-LANES:0], {LANES{1'b0}}};
        b_wide = {b_state[LEN_B-1-LANES:0], {LANES{1'b0}}};
        c_wide = {c_state[LEN_C-1-LANES:0], {LANES{1'b0}}};
        for (int j = 0; j < LANES; j++)
        begin
            a_wide[j] = lanes[LANES-1-j].fa;
            b_wide[j] = lanes[LANES-1-j].fb;
            c_wide[j] = lanes[LANES-1-j].fc;
        end
    end

    // Keystream: first round is the most significant bit
    always_comb
    begin
        keystream = '0;
        for (int k = 0; k < LANES; k++)
        begin
            keystream[LANES-1-k] = lanes[k].z;
        end
    end

    // Single round uses lane 0 only (init tail when rounds do not divide evenly)
    always_comb
    begin
        if (single_step)
        begin
            a_step = {a_state[LEN_A-2:0], lanes[0].fa};
            b_step = {b_state[LEN_B-2:0], lanes[0].fb};
            c_step = {c_state[LEN_C-2:0], lanes[0].fc};
        end
        else
        begin
            a_step = a_wide;
            b_step = b_wide;
            c_step = c_wide;
        end
    end

endmodule
